/* rtl/assert_macros.svh */
// ============================================================================
// assert_macros.svh - shared assertion macros
// Clocked assertion wrappers with an active-low asynchronous reset disable.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequence must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/lru_ipv_pkg.sv */
// ============================================================================
// lru_ipv_pkg - shared types and constants
// Command codes, register indexes, reset values and the queued item format.
// ============================================================================
`timescale 1ns / 1ps

package lru_ipv_pkg;

    localparam int POS_W    = 4;
    localparam int WAY_W    = 4;
    localparam int SET_W    = 10;
    localparam int CMD_W    = 2;
    localparam int CFG_W    = 64;
    localparam int MAX_WAYS = 16;
    localparam int TREE_LEVELS = 4;

    localparam logic [CMD_W-1:0] CMD_HIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd3;

    localparam logic [0:0] CFG_PROMO  = 1'b0;
    localparam logic [0:0] CFG_INSERT = 1'b1;

    localparam logic [CFG_W-1:0] PROMO_RESET  = 64'hB800_1501_2403_0100;
    localparam logic [POS_W-1:0] INSERT_RESET = 4'd12;

    // One classified command as it sits in the queue between front and back.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way_index;
        logic [POS_W-1:0] ins_target;
        logic             set_ok;
        logic             way_ok;
    } item_t;

endpackage

/* rtl/lru_ipv_front.sv */
// ============================================================================
// lru_ipv_front - command intake and classification
// Accepts items, checks set and way ranges and saturates the insert target.
// ============================================================================
`timescale 1ns / 1ps

module lru_ipv_front #(
    parameter int WAYS = 16,
    parameter int SETS = 1024
) (
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lru_ipv_pkg::CMD_W-1:0]       cmd,
    input  logic [lru_ipv_pkg::SET_W-1:0]       set_index,
    input  logic [lru_ipv_pkg::WAY_W-1:0]       way_index,
    input  logic [lru_ipv_pkg::POS_W-1:0]       insertion_position,
    input  logic                                clear_done,
    input  logic                                q_full,
    output logic                                push,
    output lru_ipv_pkg::item_t                  item
);

    localparam logic [lru_ipv_pkg::POS_W-1:0] OLDEST = lru_ipv_pkg::POS_W'(WAYS - 1);

    assign in_ready = clear_done && !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        item.cmd        = cmd;
        item.set_index  = set_index;
        item.way_index  = way_index;
        item.ins_target = (insertion_position > OLDEST) ? OLDEST : insertion_position;
        item.set_ok     = 32'(set_index) < 32'(SETS);
        item.way_ok     = way_index <= OLDEST;
    end

endmodule

/* rtl/lru_ipv_queue.sv */
// ============================================================================
// lru_ipv_queue - two-entry item queue
// Decouples command intake from the recency update engine.
// ============================================================================
`timescale 1ns / 1ps

module lru_ipv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lru_ipv_pkg::item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output lru_ipv_pkg::item_t pop_item
);

    lru_ipv_pkg::item_t entries_reg [0:1];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/lru_ipv_back.sv */
// ============================================================================
// lru_ipv_back - recency store and update engine
// Holds the per-set recency words, clears them after reset, applies one
// command at a time and drives the result register.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_ipv_back #(
    parameter int WAYS = 16,
    parameter int SETS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    input  lru_ipv_pkg::item_t                  q_item,
    output logic                                q_pop,
    input  logic [lru_ipv_pkg::CFG_W-1:0]       promotion_vector,
    output logic                                clear_done,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lru_ipv_pkg::WAY_W-1:0]       victim_way
);

    localparam int WORD_W = WAYS * lru_ipv_pkg::POS_W;
    localparam int ADDR_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int PAD_W  = lru_ipv_pkg::MAX_WAYS * lru_ipv_pkg::POS_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SETS - 1);
    localparam logic [lru_ipv_pkg::POS_W-1:0] OLDEST = lru_ipv_pkg::POS_W'(WAYS - 1);

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd1;
    localparam logic [ST_W-1:0] ST_EXEC  = 2'd2;

    function automatic logic [WORD_W-1:0] init_word();
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            w[i*lru_ipv_pkg::POS_W +: lru_ipv_pkg::POS_W] = lru_ipv_pkg::POS_W'(i);
        end
        return w;
    endfunction

    logic [WORD_W-1:0]  store_reg [0:SETS-1];
    logic [WORD_W-1:0]  rd_data_reg;
    lru_ipv_pkg::item_t cur_reg;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [lru_ipv_pkg::WAY_W-1:0] victim_reg, victim_next;

    logic               mem_re;
    logic               mem_we;
    logic [ADDR_W-1:0]  raddr;
    logic [ADDR_W-1:0]  waddr;
    logic [WORD_W-1:0]  wdata;
    logic [ADDR_W-1:0]  cur_addr;

    logic [PAD_W-1:0]   padded;
    logic [lru_ipv_pkg::POS_W-1:0] old_slot [0:lru_ipv_pkg::MAX_WAYS-1];
    logic [lru_ipv_pkg::POS_W-1:0] pv_slot  [0:lru_ipv_pkg::MAX_WAYS-1];
    logic [lru_ipv_pkg::POS_W-1:0] old_pos;
    logic [lru_ipv_pkg::POS_W-1:0] pv_raw;
    logic [lru_ipv_pkg::POS_W-1:0] hit_tgt;
    logic [WORD_W-1:0]  new_word;
    logic               do_write;

    logic [lru_ipv_pkg::POS_W-1:0] tp [0:lru_ipv_pkg::TREE_LEVELS][0:lru_ipv_pkg::MAX_WAYS-1];
    logic [lru_ipv_pkg::WAY_W-1:0] ti [0:lru_ipv_pkg::TREE_LEVELS][0:lru_ipv_pkg::MAX_WAYS-1];
    logic [lru_ipv_pkg::WAY_W-1:0] victim_sel;

    assign raddr      = ADDR_W'(32'(q_item.set_index));
    assign cur_addr   = ADDR_W'(32'(cur_reg.set_index));
    assign clear_done = state_reg != ST_CLEAR;
    assign out_valid  = out_valid_reg;
    assign victim_way = victim_reg;

    // Slot views of the stored word and of the promotion vector.
    always_comb
    begin
        padded = PAD_W'(rd_data_reg);
        for (int i = 0; i < lru_ipv_pkg::MAX_WAYS; i++)
        begin
            old_slot[i] = padded[i*lru_ipv_pkg::POS_W +: lru_ipv_pkg::POS_W];
            pv_slot[i]  = promotion_vector[i*lru_ipv_pkg::POS_W +: lru_ipv_pkg::POS_W];
        end
        old_pos = old_slot[cur_reg.way_index];
        pv_raw  = pv_slot[old_pos];
        hit_tgt = (pv_raw > OLDEST) ? OLDEST : pv_raw;
    end

    // Every way slot is updated in parallel from the old word.
    always_comb
    begin
        logic [lru_ipv_pkg::POS_W-1:0] p;
        logic                          is_way;
        new_word = rd_data_reg;
        for (int i = 0; i < WAYS; i++)
        begin
            p      = old_slot[i];
            is_way = lru_ipv_pkg::WAY_W'(i) == cur_reg.way_index;
            case (cur_reg.cmd)
                lru_ipv_pkg::CMD_HIT:
                begin
                    if (is_way)
                        p = hit_tgt;
                    else if (p >= hit_tgt && p < old_pos)
                        p = p + 1'b1;
                end
                lru_ipv_pkg::CMD_INSERT:
                begin
                    if (is_way)
                        p = cur_reg.ins_target;
                    else if (p >= cur_reg.ins_target && p < OLDEST)
                        p = p + 1'b1;
                end
                lru_ipv_pkg::CMD_INVAL:
                begin
                    if (is_way)
                        p = OLDEST;
                    else if (p > old_pos)
                        p = p - 1'b1;
                end
                default:
                begin
                    p = old_slot[i];
                end
            endcase
            new_word[i*lru_ipv_pkg::POS_W +: lru_ipv_pkg::POS_W] = p;
        end
    end

    // Oldest-way search as a four-level tree; the lower index wins a tie.
    always_comb
    begin
        for (int l = 0; l <= lru_ipv_pkg::TREE_LEVELS; l++)
        begin
            for (int n = 0; n < lru_ipv_pkg::MAX_WAYS; n++)
            begin
                tp[l][n] = '0;
                ti[l][n] = '0;
            end
        end
        for (int n = 0; n < lru_ipv_pkg::MAX_WAYS; n++)
        begin
            tp[0][n] = (n < WAYS) ? old_slot[n] : '0;
            ti[0][n] = lru_ipv_pkg::WAY_W'(n);
        end
        for (int l = 0; l < lru_ipv_pkg::TREE_LEVELS; l++)
        begin
            for (int n = 0; n < lru_ipv_pkg::MAX_WAYS / 2; n++)
            begin
                if (n < ((lru_ipv_pkg::MAX_WAYS / 2) >> l))
                begin
                    if (tp[l][2*n+1] > tp[l][2*n])
                    begin
                        tp[l+1][n] = tp[l][2*n+1];
                        ti[l+1][n] = ti[l][2*n+1];
                    end
                    else
                    begin
                        tp[l+1][n] = tp[l][2*n];
                        ti[l+1][n] = ti[l][2*n];
                    end
                end
            end
        end
        victim_sel = (cur_reg.cmd == lru_ipv_pkg::CMD_VICTIM && cur_reg.set_ok)
                   ? ti[lru_ipv_pkg::TREE_LEVELS][0] : '0;
    end

    assign do_write = cur_reg.set_ok && cur_reg.way_ok
                   && (cur_reg.cmd != lru_ipv_pkg::CMD_VICTIM);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        victim_next    = victim_reg;
        q_pop          = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        waddr          = clr_cnt_reg;
        wdata          = init_word();
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    victim_next    = victim_sel;
                    mem_we         = do_write;
                    waddr          = cur_addr;
                    wdata          = new_word;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        victim_reg <= victim_next;
        if (q_pop)
            cur_reg <= q_item;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_reg[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= store_reg[raddr];
    end

    `ASSERT_IMPLIES(a_no_pop_in_clear, clk, rst_n, state_reg == ST_CLEAR, !q_pop, "pop during clear")
    `ASSERT_NEXT(a_pop_then_exec, clk, rst_n, q_pop, state_reg == ST_EXEC, "pop not followed by exec")
    `ASSERT_IMPLIES(a_result_from_exec, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_EXEC, "result without exec")
    `ASSERT_IMPLIES(a_write_state, clk, rst_n, mem_we, state_reg == ST_EXEC || state_reg == ST_CLEAR, "stray write")

endmodule

/* rtl/lru_ipv_replacement.sv */
// ============================================================================
// lru_ipv_replacement - insertion/promotion vector LRU replacement state
// Usage:
// Commands arrive on the in channel (in_valid/in_ready) with cmd, set_index
// and way_index; every accepted item yields exactly one result item on the
// out channel (out_valid/out_ready) carrying victim_way, which is the oldest
// way for an in-range victim query, else zero (also hit, insert, invalidate).
// The cfg channel (cfg_valid/cfg_ready) writes promotion_vector at index 0
// and insertion_position at index 1; it is always ready and is meant to be
// used only while no item is in flight.
// An accepted item is queued, then popped and read from the recency memory
// in the idle state; the exec state applies it and loads the out register
// once that is free. The next item is popped only after this write-back.
// A two-entry queue lets the front keep accepting while a result waits.
// Reset: the recency memory is cleared to way i at position i by a pass over
// all SETS sets, one set per cycle; in_ready stays low until it completes.
// When the receiver stalls, the result holds in the out register, the
// queue fills and in_ready then drops until out_ready returns.
// ============================================================================
`timescale 1ns / 1ps

module lru_ipv_replacement #(
    parameter int WAYS = 16,
    parameter int SETS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lru_ipv_pkg::CMD_W-1:0]       cmd,
    input  logic [lru_ipv_pkg::SET_W-1:0]       set_index,
    input  logic [lru_ipv_pkg::WAY_W-1:0]       way_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lru_ipv_pkg::WAY_W-1:0]       victim_way,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [0:0]                          cfg_index,
    input  logic [lru_ipv_pkg::CFG_W-1:0]       cfg_data
);

    // Configuration registers, reset to the standard vectors.
    logic [lru_ipv_pkg::CFG_W-1:0] promo_reg, promo_next;
    logic [lru_ipv_pkg::POS_W-1:0] ins_reg, ins_next;

    logic               clear_done;
    logic               q_full;
    logic               push;
    lru_ipv_pkg::item_t push_item;
    logic               q_pop;
    logic               q_valid;
    lru_ipv_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        promo_next = promo_reg;
        ins_next   = ins_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lru_ipv_pkg::CFG_PROMO:  promo_next = cfg_data;
                lru_ipv_pkg::CFG_INSERT: ins_next   = cfg_data[lru_ipv_pkg::POS_W-1:0];
                default:                 promo_next = promo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promo_reg <= lru_ipv_pkg::PROMO_RESET;
            ins_reg   <= lru_ipv_pkg::INSERT_RESET;
        end
        else
        begin
            promo_reg <= promo_next;
            ins_reg   <= ins_next;
        end
    end

    // The front classifies each command as it is accepted.
    lru_ipv_front #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_front (
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .set_index          (set_index),
        .way_index          (way_index),
        .insertion_position (ins_reg),
        .clear_done         (clear_done),
        .q_full             (q_full),
        .push               (push),
        .item               (push_item)
    );

    lru_ipv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // The back engine owns the recency memory and the result register.
    lru_ipv_back #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .promotion_vector (promo_reg),
        .clear_done       (clear_done),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .victim_way       (victim_way)
    );

endmodule
